// File: hdl/fpm_pkg.sv
`default_nettype none

package fpm_pkg;

    localparam int DEPTH      = 4096;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int IDX_BITS   = 13;
    localparam int PTR_BITS   = IDX_BITS + 1;
    localparam int VALUE_BITS = 16;
    localparam int EPOCH_BITS = 16;
    localparam int WORD_BITS  = EPOCH_BITS + VALUE_BITS;
    localparam int SIZE_BITS  = 13;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(4096);

    // request codes
    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_EPOCH  = 2'd2;

    // register select, paddr[2]
    localparam logic REG_SIZE_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY
    } state_t;

    typedef struct packed {
        logic                 en;
        logic                 we;
        logic [ADDR_BITS-1:0] addr;
        logic [WORD_BITS-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic                  valid;
        logic [VALUE_BITS-1:0] data;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/fpm_ram.sv
`default_nettype none

module fpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/fpm_cfg.sv
`default_nettype none

module fpm_cfg
    import fpm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [PDATA_BITS-1:0] pwdata,
    output logic      [PDATA_BITS-1:0] prdata,
    output logic                       pready,
    output logic      [SIZE_BITS-1:0]  size_in_use
);

    logic [SIZE_BITS-1:0] size_reg;
    logic [SIZE_BITS-1:0] size_next;
    logic                 wr_en;

    assign wr_en = psel && penable && pwrite && (paddr[2] == REG_SIZE_IN_USE);

    always_comb
    begin
        size_next = size_reg;
        if (wr_en)
        begin
            size_next = pwdata[SIZE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else
        begin
            size_reg <= size_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_SIZE_IN_USE)
        begin
            prdata = PDATA_BITS'(size_reg);
        end
    end

    assign pready      = 1'b1;
    assign size_in_use = size_reg;

endmodule

`default_nettype wire

// File: hdl/fpm_engine.sv
`default_nettype none

module fpm_engine
    import fpm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [1:0]            req_type,
    input  wire logic [IDX_BITS-1:0]   index,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire logic [SIZE_BITS-1:0]  size_in_use,
    input  wire logic [WORD_BITS-1:0]  mem_rdata,
    output logic                       busy,
    output mem_req_t                   mem_req,
    output result_t                    result
);

    state_t                 state_reg, state_next;
    logic [PTR_BITS-1:0]    ptr_reg, ptr_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    logic [VALUE_BITS-1:0]  best_reg, best_next;
    logic                   is_query_reg, is_query_next;
    logic [EPOCH_BITS-1:0]  epoch_reg, epoch_next;
    logic [ADDR_BITS-1:0]   clr_reg, clr_next;
    logic                   res_valid_reg, res_valid_next;
    logic [VALUE_BITS-1:0]  res_data_reg, res_data_next;

    logic [IDX_BITS-1:0]    limit;
    logic [IDX_BITS-1:0]    qidx;
    logic [EPOCH_BITS-1:0]  epoch_inc;
    logic [EPOCH_BITS-1:0]  node_stamp;
    logic [VALUE_BITS-1:0]  node_raw;
    logic [VALUE_BITS-1:0]  node_val;
    logic [VALUE_BITS-1:0]  new_max;
    logic [VALUE_BITS-1:0]  best_new;
    logic [PTR_BITS-1:0]    low;
    logic [PTR_BITS-1:0]    ptr_up;
    logic [PTR_BITS-1:0]    ptr_down;
    logic [PTR_BITS-1:0]    ptr_m1;
    logic                   upd_ok;

    assign limit     = (size_in_use > SIZE_BITS'(DEPTH)) ? IDX_BITS'(DEPTH) : size_in_use;
    assign qidx      = (index > IDX_BITS'(DEPTH)) ? IDX_BITS'(DEPTH) : index;
    assign epoch_inc = epoch_reg + EPOCH_BITS'(1);
    assign upd_ok    = (index != '0) && (index <= limit);

    // a node stamped in an older epoch reads as zero
    assign node_stamp = mem_rdata[WORD_BITS-1:VALUE_BITS];
    assign node_raw   = mem_rdata[VALUE_BITS-1:0];
    assign node_val   = (node_stamp == epoch_reg) ? node_raw : '0;
    assign new_max    = (node_val > val_reg) ? node_val : val_reg;
    assign best_new   = (node_val > best_reg) ? node_val : best_reg;

    assign low      = ptr_reg & (~ptr_reg + PTR_BITS'(1));
    assign ptr_up   = ptr_reg + low;
    assign ptr_down = ptr_reg - low;
    assign ptr_m1   = ptr_reg - PTR_BITS'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == ADDR_BITS'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (req_type)
                        REQ_UPDATE:
                        begin
                            if (upd_ok)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        REQ_QUERY:
                        begin
                            if (index != '0)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        REQ_EPOCH:
                        begin
                            // wrap to zero: sweep the stamps and values
                            if (epoch_inc == '0)
                            begin
                                state_next = ST_CLEAR;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                if (is_query_reg)
                begin
                    state_next = (ptr_down == '0) ? ST_IDLE : ST_READ;
                end
                else
                begin
                    state_next = (ptr_up > PTR_BITS'(limit)) ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        ptr_next       = ptr_reg;
        val_next       = val_reg;
        best_next      = best_reg;
        is_query_next  = is_query_reg;
        epoch_next     = epoch_reg;
        clr_next       = clr_reg;
        res_valid_next = 1'b0;
        res_data_next  = res_data_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + ADDR_BITS'(1);
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    val_next      = value;
                    best_next     = '0;
                    is_query_next = (req_type == REQ_QUERY);
                    unique case (req_type)
                        REQ_UPDATE:
                        begin
                            ptr_next = PTR_BITS'(index);
                        end
                        REQ_QUERY:
                        begin
                            ptr_next = PTR_BITS'(qidx);
                            if (index == '0)
                            begin
                                res_valid_next = 1'b1;
                                res_data_next  = '0;
                            end
                        end
                        REQ_EPOCH:
                        begin
                            epoch_next = epoch_inc;
                            clr_next   = '0;
                        end
                        default:
                        begin
                            ptr_next = ptr_reg;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                ptr_next = ptr_reg;
            end
            ST_MODIFY:
            begin
                if (is_query_reg)
                begin
                    ptr_next  = ptr_down;
                    best_next = best_new;
                    if (ptr_down == '0)
                    begin
                        res_valid_next = 1'b1;
                        res_data_next  = best_new;
                    end
                end
                else
                begin
                    ptr_next = ptr_up;
                end
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            epoch_reg     <= '0;
            clr_reg       <= '0;
            is_query_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            clr_reg       <= clr_next;
            is_query_reg  <= is_query_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        val_reg      <= val_next;
        best_reg     <= best_next;
        res_data_reg <= res_data_next;
    end

    // outputs
    always_comb
    begin
        mem_req.en    = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.addr  = ptr_m1[ADDR_BITS-1:0];
        mem_req.wdata = {epoch_reg, new_max};
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = clr_reg;
                mem_req.wdata = '0;
            end
            ST_READ:
            begin
                mem_req.en = 1'b1;
            end
            ST_MODIFY:
            begin
                // queries never write back: a stale node reads zero either way
                mem_req.en = !is_query_reg;
                mem_req.we = !is_query_reg;
            end
            default:
            begin
                mem_req.en = 1'b0;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

endmodule

`default_nettype wire

// File: hdl/fenwick_prefix_max_epoch_clear.sv
// Prefix-maximum binary indexed tree with epoch-based lazy clearing.
//
// Command channel: a transaction is taken when start is high and busy is low.
// req_type selects update (raise every covering node from index upward to at
// least value), prefix max query over 1..index, or new epoch. Update and
// epoch transactions produce no result.
// Result channel: done pulses for one cycle with prefix_max; there is no
// back pressure, so the result must be taken in that cycle.
// Config: APB register size_in_use at byte address 0 (limit of updates).
//
// Each tree node visit is a read of the single node RAM then a modify step
// that writes the node back for updates only. An update visits every covering
// node from index up to the size limit; a query visits one node per set bit
// of the index (clamped to 4096), and done is high in the first cycle with
// busy low. An ignored update, a query at index zero and a non-wrapping epoch
// step do not raise busy. After reset, and when the epoch counter wraps to
// zero, busy stays high for a pass that clears every node; configuration
// writes are still accepted during it.
`default_nettype none

module fenwick_prefix_max_epoch_clear
    import fpm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            req_type,
    input  wire logic [IDX_BITS-1:0]   index,
    input  wire logic [VALUE_BITS-1:0] value,
    output logic                       done,
    output logic      [VALUE_BITS-1:0] prefix_max,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [PDATA_BITS-1:0] pwdata,
    output logic      [PDATA_BITS-1:0] prdata,
    output logic                       pready
);

    logic [SIZE_BITS-1:0] size_in_use;
    logic [WORD_BITS-1:0] mem_rdata;
    mem_req_t             mem_req;
    result_t              result;

    fpm_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .size_in_use (size_in_use)
    );

    fpm_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req_type    (req_type),
        .index       (index),
        .value       (value),
        .size_in_use (size_in_use),
        .mem_rdata   (mem_rdata),
        .busy        (busy),
        .mem_req     (mem_req),
        .result      (result)
    );

    // node word: {stamp, max}
    fpm_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

    assign done       = result.valid;
    assign prefix_max = result.data;

endmodule

`default_nettype wire

// File: hdl/fpm_chk.sv
`default_nettype none

module fpm_chk
    import fpm_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic [1:0]            req_type,
    input wire logic [IDX_BITS-1:0]   index,
    input wire logic                  done,
    input wire logic [VALUE_BITS-1:0] prefix_max,
    input wire logic                  pready
);

    logic accept;

    assign accept = start && !busy;

    // a query that walks the tree must hold off the next transaction
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req_type == REQ_QUERY) && (index != '0) |=> busy)
        else $error("query walk did not raise busy");

    // empty prefix answers zero on the next cycle
    a_query_zero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req_type == REQ_QUERY) && (index == '0)
        |=> done && (prefix_max == '0))
        else $error("query at index zero did not answer zero");

    // only queries produce results
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req_type != REQ_QUERY) |=> !done)
        else $error("result after a non-query transaction");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind fenwick_prefix_max_epoch_clear fpm_chk u_fpm_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .index      (index),
    .done       (done),
    .prefix_max (prefix_max),
    .pready     (pready)
);

`default_nettype wire

// File: sim/tb_fenwick_prefix_max_epoch_clear.sv
`default_nettype none

module tb_fenwick_prefix_max_epoch_clear;
    import fpm_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE      = 40;

    // unassigned request code, must be ignored
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef struct {
        logic [1:0]            kind;
        logic [IDX_BITS-1:0]   idx;
        logic [VALUE_BITS-1:0] val;
        int                    gap_pct;
        bit                    drain;       // hold until all results are back
    } cmd_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start    = 1'b0;
    logic                  busy;
    logic [1:0]            req_type = REQ_UPDATE;
    logic [IDX_BITS-1:0]   index    = '0;
    logic [VALUE_BITS-1:0] value    = '0;
    logic                  done;
    logic [VALUE_BITS-1:0] prefix_max;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [PADDR_BITS-1:0] paddr    = '0;
    logic [PDATA_BITS-1:0] pwdata   = '0;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    fenwick_prefix_max_epoch_clear dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .index      (index),
        .value      (value),
        .done       (done),
        .prefix_max (prefix_max),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    cmd_t                  cmd_q[$];
    logic [VALUE_BITS-1:0] max_expect_q[$];

    // tree mirror
    logic [VALUE_BITS-1:0] node_val [1:DEPTH];
    logic [EPOCH_BITS-1:0] node_ep  [1:DEPTH];
    logic [EPOCH_BITS-1:0] cur_epoch;
    logic [SIZE_BITS-1:0]  size_lim;

    int err_cnt     = 0;
    int query_cnt   = 0;
    int update_cnt  = 0;
    int epoch_cnt   = 0;
    int wrap_cnt    = 0;
    int size_cnt    = 0;
    int cycle_cnt   = 0;

    function automatic void tree_clear();
        for (int i = 1; i <= DEPTH; i++)
        begin
            node_val[i] = '0;
            node_ep[i]  = '0;
        end
    endfunction

    // lazy clear: a node stamped in an older epoch reads as zero
    function automatic logic [VALUE_BITS-1:0] fresh_node(int i);
        if (node_ep[i] != cur_epoch)
        begin
            node_ep[i]  = cur_epoch;
            node_val[i] = '0;
        end
        return node_val[i];
    endfunction

    function automatic void raise_nodes(int idx, logic [VALUE_BITS-1:0] val);
        int lim;
        lim = (size_lim > DEPTH) ? DEPTH : int'(size_lim);
        if (idx == 0 || idx > lim)
            return;
        for (int i = idx; i <= lim; i += i & -i)
            if (fresh_node(i) < val)
                node_val[i] = val;
    endfunction

    function automatic logic [VALUE_BITS-1:0] prefix_of(int idx);
        logic [VALUE_BITS-1:0] best;
        logic [VALUE_BITS-1:0] v;
        int                    i;
        best = '0;
        i = (idx > DEPTH) ? DEPTH : idx;
        while (i != 0)
        begin
            v = fresh_node(i);
            if (v > best)
                best = v;
            i -= i & -i;
        end
        return best;
    endfunction

    function automatic void bump_epoch();
        cur_epoch = cur_epoch + 1'b1;
        epoch_cnt++;
        if (cur_epoch == '0)
        begin
            tree_clear();
            wrap_cnt++;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // command driver
    always @(posedge clk)
    begin : drv
        cmd_t nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!(start && busy))
        begin
            if (cmd_q.size() != 0 && $urandom_range(0, 99) >= cmd_q[0].gap_pct
                    && !(cmd_q[0].drain && (start || max_expect_q.size() != 0)))
            begin
                nxt = cmd_q.pop_front();
                start    <= 1'b1;
                req_type <= nxt.kind;
                index    <= nxt.idx;
                value    <= nxt.val;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check results, track config writes and accepted transactions
    always @(posedge clk)
    begin : mon
        logic [VALUE_BITS-1:0] want;
        if (!rst_n)
        begin
            tree_clear();
            cur_epoch = '0;
            size_lim  = SIZE_RESET;
        end
        else
        begin
            if (done)
            begin
                if (max_expect_q.size() == 0)
                begin
                    err_cnt++;
                    $error("unexpected result: prefix_max=%0h", prefix_max);
                end
                else
                begin
                    want = max_expect_q.pop_front();
                    query_cnt++;
                    if (prefix_max !== want)
                    begin
                        err_cnt++;
                        $error("prefix_max: expected %0h, got %0h", want, prefix_max);
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_SIZE_IN_USE)
                size_lim = pwdata[SIZE_BITS-1:0];
            if (start && !busy)
            begin
                case (req_type)
                    REQ_UPDATE:
                    begin
                        raise_nodes(int'(index), value);
                        update_cnt++;
                    end
                    REQ_QUERY: max_expect_q.push_back(prefix_of(int'(index)));
                    REQ_EPOCH: bump_epoch();
                    default: ;
                endcase
            end
        end
    end

    function automatic void push_cmd(logic [1:0] kind, int idx, int val,
                                     int gap_pct = 0, bit drain = 1'b0);
        cmd_t c;
        c.kind    = kind;
        c.idx     = IDX_BITS'(idx);
        c.val     = VALUE_BITS'(val);
        c.gap_pct = gap_pct;
        c.drain   = drain;
        cmd_q.push_back(c);
    endfunction

    function automatic int rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return 16'hFFFF;
        return $urandom_range(0, 16'hFFFF);
    endfunction

    // mostly in-range updates and queries, some out-of-range, epoch steps and noise
    function automatic void push_random(int lim_cfg, int gap_pct, bit drain);
        int eff;
        int r;
        int p;
        int idx;
        logic [1:0] kind;
        eff = (lim_cfg == 0) ? 1 : ((lim_cfg > DEPTH) ? DEPTH : lim_cfg);
        r = $urandom_range(0, 99);
        p = $urandom_range(0, 99);
        if (r < 52)
        begin
            kind = REQ_UPDATE;
            if (p < 85)
                idx = $urandom_range(1, eff);
            else if (p < 90)
                idx = 0;
            else if (p < 95)
                idx = eff + 1;
            else
                idx = $urandom_range(0, 8191);
        end
        else if (r < 96)
        begin
            kind = REQ_QUERY;
            if (p < 80)
                idx = $urandom_range(0, eff);
            else if (p < 85)
                idx = eff;
            else
                idx = $urandom_range(0, 8191);
        end
        else if (r < 99)
        begin
            kind = REQ_EPOCH;
            idx  = $urandom_range(0, 8191);
        end
        else
        begin
            kind = REQ_NONE;
            idx  = $urandom_range(0, 8191);
        end
        push_cmd(kind, idx, rand_value(), gap_pct, drain);
    endfunction

    task automatic wait_idle();
        while (cmd_q.size() != 0 || start || max_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic set_size(int sz);
        wait_idle();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= '0;
        pwdata  <= PDATA_BITS'(sz);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_cnt++;
    endtask

    task automatic random_phase(int sz, int n, int gap_pct, int drain_at);
        set_size(sz);
        for (int k = 0; k < n; k++)
            push_random(sz, gap_pct, k == drain_at);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: edges of index and value, ignored cases, epoch step
        push_cmd(REQ_QUERY,  0,      0);
        push_cmd(REQ_QUERY,  4096,   0);
        push_cmd(REQ_UPDATE, 0,      16'hFFFF);
        push_cmd(REQ_UPDATE, 1,      16'h1234);
        push_cmd(REQ_UPDATE, 4096,   16'hFFFF);
        push_cmd(REQ_UPDATE, 4097,   16'h5555);
        push_cmd(REQ_UPDATE, 8191,   16'hAAAA);
        push_cmd(REQ_QUERY,  1,      0);
        push_cmd(REQ_QUERY,  4095,   0);
        push_cmd(REQ_QUERY,  4096,   0);
        push_cmd(REQ_QUERY,  8191,   16'hFFFF);
        push_cmd(REQ_NONE,   5,      7);
        push_cmd(REQ_UPDATE, 12'hAAA, 16'h8000);
        push_cmd(REQ_UPDATE, 12'h555, 16'h7FFF);
        push_cmd(REQ_UPDATE, 3,      0);
        push_cmd(REQ_QUERY,  12'hAAA, 0);
        push_cmd(REQ_QUERY,  12'h555, 0);
        push_cmd(REQ_QUERY,  2,      0);
        push_cmd(REQ_EPOCH,  0,      0);
        push_cmd(REQ_QUERY,  4096,   0);
        push_cmd(REQ_UPDATE, 5,      9);
        push_cmd(REQ_QUERY,  5,      0);
        push_cmd(REQ_QUERY,  4,      0);

        random_phase(4096, 250,  0, -1);
        random_phase(1,    100,  0, 40);
        random_phase(8191, 150, 85, -1);
        random_phase(0,     50, 23, -1);
        random_phase($urandom_range(2, 4095), 250, 23, 120);
        random_phase(16,   150, 85, 60);
        random_phase(4096, 100,  0, -1);

        // back-to-back epoch steps with live data in the tree
        for (int k = 0; k < 12; k++)
            push_cmd(REQ_UPDATE, $urandom_range(1, DEPTH), rand_value());
        push_cmd(REQ_QUERY, DEPTH, 0);
        for (int k = 0; k < 4; k++)
            push_cmd(REQ_EPOCH, 0, 0);
        push_cmd(REQ_QUERY, DEPTH, 0);
        push_cmd(REQ_QUERY, 1, 0);
        for (int k = 0; k < 200; k++)
            push_random(4096, 23, 1'b0);

        wait_idle();
        $display("Checked %0d query results over %0d updates and %0d epoch steps (%0d wraps),",
                 query_cnt, update_cnt, epoch_cnt, wrap_cnt);
        $display("with %0d size_in_use settings and sender gaps of 0, 23 and 85 percent.",
                 size_cnt);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hdl/fpm_pkg.sv
hdl/fpm_ram.sv
hdl/fpm_cfg.sv
hdl/fpm_engine.sv
hdl/fenwick_prefix_max_epoch_clear.sv
hdl/fpm_chk.sv
sim/tb_fenwick_prefix_max_epoch_clear.sv
